// ===== design/largest_prime_factor_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LARGEST_PRIME_FACTOR_MACROS_SVH
`define LARGEST_PRIME_FACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("largest_prime_factor: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("largest_prime_factor: next-cycle check failed");

`endif

// ===== design/lpf_pkg.sv =====
package lpf_pkg;

    localparam int FIELD_WIDTH = 32;

    // First trial divisor and first wheel candidate.
    localparam int FIRST_PRIME = 2;
    localparam int WHEEL_START = 7;

    // Gaps between successive candidates of the mod-30 wheel, starting at 7.
    localparam logic [2:0] WHEEL_DELTA [8] = '{
        3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd6, 3'd2, 3'd6
    };

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic take_quot;
        logic next_cand;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic below_two;
        logic bound;
        logic exact;
    } t_dp_sts;

endpackage

// ===== design/lpf_datapath.sv =====
module lpf_datapath
    import lpf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  t_dp_cmd                i_cmd,
    input  logic [FIELD_WIDTH-1:0] i_value,
    output t_dp_sts                o_sts,
    output logic [FIELD_WIDTH-1:0] o_largest_factor,
    output logic                   o_no_factor
);

    localparam int VW = VALUE_WIDTH;

    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_cand;
    logic [VW-1:0] r_largest;
    logic [VW-1:0] r_part;
    logic [VW-1:0] r_quot;
    logic [VW-1:0] r_out_largest;
    logic          r_nofac;
    logic          r_out_nofac;
    logic [2:0]    r_wheel;

    logic [VW:0]   w_trial;
    logic [VW-1:0] n_cand;
    logic [VW-1:0] w_value;

    assign w_value = VW'(i_value);

    // One restoring division step: shift in the next dividend bit, try the subtract.
    assign w_trial = {r_part, r_quot[VW-1]} - {1'b0, r_cand};

    always_comb begin
        if (r_cand < VW'(WHEEL_START)) begin
            if (r_cand == VW'(FIRST_PRIME)) begin
                n_cand = VW'(3);
            end else if (r_cand == VW'(3)) begin
                n_cand = VW'(5);
            end else begin
                n_cand = VW'(WHEEL_START);
            end
        end else begin
            n_cand = r_cand + VW'(WHEEL_DELTA[r_wheel]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem     <= w_value;
            r_cand    <= VW'(FIRST_PRIME);
            r_largest <= '0;
            r_wheel   <= '0;
            r_nofac   <= (w_value < VW'(2));
        end
        if (i_cmd.div_start) begin
            r_part <= '0;
            r_quot <= r_rem;
        end
        if (i_cmd.div_step) begin
            if (!w_trial[VW]) begin
                r_part <= w_trial[VW-1:0];
                r_quot <= {r_quot[VW-2:0], 1'b1};
            end else begin
                r_part <= {r_part[VW-2:0], r_quot[VW-1]};
                r_quot <= {r_quot[VW-2:0], 1'b0};
            end
        end
        if (i_cmd.take_quot) begin
            r_rem     <= r_quot;
            r_largest <= r_cand;
        end
        if (i_cmd.next_cand) begin
            r_cand <= n_cand;
            if (r_cand >= VW'(WHEEL_START)) begin
                r_wheel <= r_wheel + 3'd1;
            end
        end
        if (i_cmd.finish) begin
            // Whatever is left above 6 has no factor below its square root.
            r_out_largest <= (r_rem > VW'(6)) ? r_rem : r_largest;
            r_out_nofac   <= r_nofac;
        end
    end

    // The bound only applies to wheel candidates; 2, 3 and 5 are always stripped.
    assign o_sts.below_two = (r_rem < VW'(2));
    assign o_sts.bound     = (r_cand >= VW'(WHEEL_START)) && (r_quot < r_cand);
    assign o_sts.exact     = (r_part == '0);

    assign o_largest_factor = FIELD_WIDTH'(r_out_largest);
    assign o_no_factor      = r_out_nofac;

endmodule

// ===== design/lpf_ctrl.sv =====
module lpf_ctrl
    import lpf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.below_two) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = CW'(VALUE_WIDTH - 1);
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_DECIDE: begin
                if (i_sts.bound) begin
                    n_state = S_DONE;
                end else if (i_sts.exact) begin
                    // Divide again by the same candidate until it no longer divides.
                    o_cmd.take_quot = 1'b1;
                    n_state         = S_START;
                end else begin
                    o_cmd.next_cand = 1'b1;
                    n_state         = S_START;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== design/largest_prime_factor.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------
// input    | in        | i_valid / o_stall  | i_value
// output   | out       | o_valid / i_stall  | o_largest_factor, o_no_factor
//
// Each trial division runs a restoring divider one quotient bit per cycle; a value of 0 or 1
// skips the divider and goes straight from the start state to the done state.
// The work for an item grows with the number of trial divisions it needs.
// One item is worked on at a time; a new beat is taken while the previous result waits.
// Synchronous active-low reset clears the controller and the output valid.
// A stalled output holds its beat, and the next result waits for it to leave.
module largest_prime_factor
    import lpf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [FIELD_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [FIELD_WIDTH-1:0] o_largest_factor,
    output logic                   o_no_factor
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lpf_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lpf_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_value          (i_value),
        .o_sts            (w_sts),
        .o_largest_factor (o_largest_factor),
        .o_no_factor      (o_no_factor)
    );

endmodule

// ===== design/lpf_checker.sv =====
`include "largest_prime_factor_macros.svh"

module lpf_checker
    import lpf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic [FIELD_WIDTH-1:0] i_value,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [FIELD_WIDTH-1:0] o_largest_factor,
    input logic                   o_no_factor
);

    // A stalled result beat holds.
    `LPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_largest_factor) && $stable(o_no_factor))

    // A value without prime factors reports zero.
    `LPF_ASSERT_SAME(a_nofac_zero, i_clk, i_rst_n, o_valid && o_no_factor, o_largest_factor == '0)

    // Any reported factor is at least two.
    `LPF_ASSERT_SAME(a_factor_min, i_clk, i_rst_n, o_valid && !o_no_factor, o_largest_factor >= FIELD_WIDTH'(2))

    // Once a beat is taken the block is busy on it.
    `LPF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

bind largest_prime_factor lpf_checker u_lpf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_value          (i_value),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_largest_factor (o_largest_factor),
    .o_no_factor      (o_no_factor)
);
